// ===== rtl/urt_pkg.sv =====
// urt_pkg: shared types and constants for the ultrasonic range timer.
// Used by urt_core and ultrasonic_range_timer; no dependencies.
`timescale 1ns / 1ps

package urt_pkg;

  // Width of the burst tick counter and the echo tick counter (8 to 32).
  localparam int COUNT_WIDTH = 16;
  localparam int PROD_W      = COUNT_WIDTH + 16;
  localparam int DIST_W      = 11;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BURST       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_LIMIT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE       = 2'd3;

  localparam logic [15:0] RST_HALF_PERIOD = 16'd12;
  localparam logic [7:0]  RST_BURST       = 8'd10;
  localparam logic [15:0] RST_ECHO_LIMIT  = 16'd65535;
  localparam logic [15:0] RST_SCALE       = 16'd1114;  // 0.017 in Q0.16

  localparam logic [DIST_W-1:0] TIMEOUT_CM = 11'd999;
  localparam logic [DIST_W-1:0] DIST_MAX   = 11'd2047;

  typedef struct packed {
    logic [15:0] half_period_ticks;
    logic [7:0]  burst_toggles;
    logic [15:0] echo_limit;
    logic [15:0] scale_q16;
  } cfg_t;

  typedef struct packed {
    logic              trigger;
    logic              busy;
    logic              done;
    logic              timed_out;
    logic [DIST_W-1:0] distance_cm;
  } result_t;

endpackage

// ===== rtl/urt_core.sv =====
// urt_core: burst / echo sequencer state and its one-tick update logic.
// Depends on urt_pkg.
`timescale 1ns / 1ps

module urt_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             start_req,
  input  logic             echo_level,
  input  urt_pkg::cfg_t    cfg,
  output urt_pkg::result_t res
);
  import urt_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_BURST = 2'd1,
    PH_ECHO  = 2'd2
  } phase_t;

  phase_t                 phase, phase_next;
  logic [COUNT_WIDTH-1:0] tick_count, tick_count_next;
  logic [7:0]             toggles_left, toggles_left_next;
  logic [COUNT_WIDTH-1:0] echo_count, echo_count_next;
  logic                   trigger_level, trigger_level_next;
  logic [DIST_W-1:0]      last_distance, last_distance_next;
  logic                   done, timed_out;

  logic [COUNT_WIDTH-1:0] tick_inc, echo_inc;
  logic [7:0]             toggles_dec;
  logic                   half_hit, echo_hit;
  logic [PROD_W-1:0]      prod;
  logic [COUNT_WIDTH-1:0] dist_full;
  logic [DIST_W-1:0]      dist_sat;

  assign tick_inc    = tick_count + 1'b1;
  assign echo_inc    = echo_count + 1'b1;
  assign toggles_dec = toggles_left - 8'd1;
  // a counter stuck at all ones counts as reaching its limit
  assign half_hit = (32'(tick_inc) >= 32'(cfg.half_period_ticks)) || (&tick_inc);
  assign echo_hit = (32'(echo_inc) >= 32'(cfg.echo_limit)) || (&echo_inc);

  // cm = floor(count * scale / 2^16), clipped to the 11-bit range
  assign prod      = PROD_W'(echo_count) * PROD_W'(cfg.scale_q16);
  assign dist_full = prod[PROD_W-1:16];
  assign dist_sat  = (32'(dist_full) > 32'(DIST_MAX)) ? DIST_MAX : DIST_W'(32'(dist_full));

  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    toggles_left_next  = toggles_left;
    echo_count_next    = echo_count;
    trigger_level_next = trigger_level;
    last_distance_next = last_distance;
    done               = 1'b0;
    timed_out          = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (start_req) begin
          trigger_level_next = 1'b0;
          tick_count_next    = '0;
          toggles_left_next  = cfg.burst_toggles;
          if (cfg.burst_toggles == 8'd0) begin
            phase_next      = PH_ECHO;
            echo_count_next = '0;
          end else begin
            phase_next = PH_BURST;
          end
        end
      end
      PH_BURST: begin
        tick_count_next = tick_inc;
        if (half_hit) begin
          trigger_level_next = ~trigger_level;
          tick_count_next    = '0;
          toggles_left_next  = toggles_dec;
          if (toggles_dec == 8'd0) begin
            phase_next      = PH_ECHO;
            echo_count_next = '0;
          end
        end
      end
      PH_ECHO: begin
        if (!echo_level) begin
          last_distance_next = dist_sat;
          done               = 1'b1;
          phase_next         = PH_IDLE;
        end else begin
          echo_count_next = echo_inc;
          if (echo_hit) begin
            last_distance_next = TIMEOUT_CM;
            done               = 1'b1;
            timed_out          = 1'b1;
            phase_next         = PH_IDLE;
          end
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      toggles_left  <= '0;
      echo_count    <= '0;
      trigger_level <= 1'b0;
      last_distance <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      toggles_left  <= toggles_left_next;
      echo_count    <= echo_count_next;
      trigger_level <= trigger_level_next;
      last_distance <= last_distance_next;
    end
  end

  // result of the tick being taken, registered by the top level
  assign res.trigger     = trigger_level_next;
  assign res.busy        = (phase_next != PH_IDLE);
  assign res.done        = done;
  assign res.timed_out   = timed_out;
  assign res.distance_cm = last_distance_next;

endmodule

// ===== rtl/ultrasonic_range_timer.sv =====
// ultrasonic_range_timer: top level with configuration registers and result register.
// Depends on urt_pkg and urt_core.
`timescale 1ns / 1ps

// Ultrasonic time-of-flight ranger, one input beat per 1 us timer tick.
//
// Input channel (in_valid / in_ready): start_req, echo_level for one tick.
// Output channel (out_valid / out_ready): one result beat per input beat:
//   trigger, busy_res, done_res, timed_out, distance_cm.
// A start in idle sends a burst of burst_toggles trigger edges spaced
// half_period_ticks apart, then counts ticks while echo_level is high.
// Echo low ends it with distance = floor(count * scale_q16 / 2^16) cm,
// clipped to 2047; reaching echo_limit ends it with timed_out and 999.
//
// A tick's result is registered; it is on the output the cycle after its
// beat is taken. Throughput: one tick per cycle; the per-tick update is a
// single pass through the sequencer and one 16 x COUNT_WIDTH multiplier.
// The single output register is refilled in the cycle it is drained, so
// in_ready = !out_valid || out_ready. When the receiver stalls, in_ready
// drops and the sequencer state holds until the waiting beat is taken.
//
// Reset (rst, synchronous): sequencer idle, trigger low, last distance 0,
// output empty, configuration back to 12 / 10 / 65535 / 1114.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once;
// write only while no measurement is in progress.

module ultrasonic_range_timer (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_we,
  input  logic [urt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [urt_pkg::CFG_DATA_W-1:0] cfg_data,
  // tick input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           start_req,
  input  logic                           echo_level,
  // result output
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           trigger,
  output logic                           busy_res,
  output logic                           done_res,
  output logic                           timed_out,
  output logic [urt_pkg::DIST_W-1:0]     distance_cm
);
  import urt_pkg::*;

  cfg_t    cfg;
  result_t res_comb;
  result_t res_q;
  logic    in_beat;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period_ticks <= RST_HALF_PERIOD;
      cfg.burst_toggles     <= RST_BURST;
      cfg.echo_limit        <= RST_ECHO_LIMIT;
      cfg.scale_q16         <= RST_SCALE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HALF_PERIOD: cfg.half_period_ticks <= cfg_data;
        REG_BURST:       cfg.burst_toggles     <= cfg_data[7:0];
        REG_ECHO_LIMIT:  cfg.echo_limit        <= cfg_data;
        REG_SCALE:       cfg.scale_q16         <= cfg_data;
        default: ;
      endcase
    end
  end

  // output register drains and refills in the same cycle
  assign in_ready = !out_valid || out_ready;
  assign in_beat  = in_valid && in_ready;

  urt_core u_core (
    .clk        (clk),
    .rst        (rst),
    .advance    (in_beat),
    .start_req  (start_req),
    .echo_level (echo_level),
    .cfg        (cfg),
    .res        (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_beat) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (in_beat) begin
      res_q <= res_comb;
    end
  end

  assign trigger     = res_q.trigger;
  assign busy_res    = res_q.busy;
  assign done_res    = res_q.done;
  assign timed_out   = res_q.timed_out;
  assign distance_cm = res_q.distance_cm;

  // every taken tick yields a result beat on the next cycle
  a_beat_yields_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("tick taken without a result beat");

  // a completed measurement leaves the sequencer idle
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done reported while still busy");

  // a timeout is always a completion reporting the timeout distance
  a_timeout_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && timed_out |-> done_res && (distance_cm == TIMEOUT_CM))
    else $error("timeout without done or with wrong distance");

  // distance only changes on a completing tick
  a_distance_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && $past(out_valid) && !$past(rst) && !done_res
      |-> distance_cm == $past(distance_cm))
    else $error("distance changed without a completion");

endmodule

// ===== dv/tb.sv =====
// tb: self-checking bench for ultrasonic_range_timer, one beat per timer tick.
// Depends on urt_pkg and the ultrasonic_range_timer RTL; needs no other files.
`timescale 1ns / 1ps

module tb;
  import urt_pkg::*;

  // A correct run ends before this limit even with every gap and stall at its
  // longest.
  localparam int LIMIT_CYCLES = 200_000;
  localparam int MAX_PRINTS   = 50;

  typedef enum logic [1:0] {PH_IDLE, PH_BURST, PH_ECHO} range_phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic              in_valid   = 1'b0;
  logic              start_req  = 1'b0;
  logic              echo_level = 1'b0;
  logic              out_ready  = 1'b0;
  logic              in_ready;
  logic              out_valid;
  logic              trigger;
  logic              busy_res;
  logic              done_res;
  logic              timed_out;
  logic [DIST_W-1:0] distance_cm;

  // Predictor: configuration copy and measurement state
  logic [15:0]            cfg_half    = RST_HALF_PERIOD;
  logic [7:0]             cfg_toggles = RST_BURST;
  logic [15:0]            cfg_limit   = RST_ECHO_LIMIT;
  logic [15:0]            cfg_scale   = RST_SCALE;
  range_phase_t           phase_q      = PH_IDLE;
  logic [COUNT_WIDTH-1:0] burst_ticks  = '0;
  logic [7:0]             toggles_left = '0;
  logic [COUNT_WIDTH-1:0] echo_ticks   = '0;
  logic                   trig_level   = 1'b0;
  logic [DIST_W-1:0]      last_cm      = '0;

  // Tick results still owed by the DUT, oldest first
  result_t pending_results[$];

  int errors        = 0;
  int cycle_count   = 0;
  int ticks_sent    = 0;
  bit idle_on       = 1'b1;  // random gaps on both sides
  // Long receiver hold: tests post a request, the receiver process serves it
  int hold_len      = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int stall_left    = 0;

  ultrasonic_range_timer DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .start_req  (start_req),
    .echo_level (echo_level),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .trigger    (trigger),
    .busy_res   (busy_res),
    .done_res   (done_res),
    .timed_out  (timed_out),
    .distance_cm(distance_cm)
  );

  always #10 clk = ~clk;

  // Advance the predicted ranger by one tick and return what that tick reports.
  function automatic result_t advance_tick(input logic start, input logic echo);
    result_t                r;
    logic [PROD_W-1:0]      prod;
    logic [COUNT_WIDTH-1:0] cm_full;
    r = '0;
    case (phase_q)
      PH_IDLE: begin
        // start is only honored here; while busy it is ignored
        if (start) begin
          trig_level   = 1'b0;
          burst_ticks  = '0;
          toggles_left = cfg_toggles;
          if (toggles_left == 8'd0) begin
            phase_q    = PH_ECHO;  // empty burst: straight to the echo wait
            echo_ticks = '0;
          end else begin
            phase_q = PH_BURST;
          end
        end
      end
      PH_BURST: begin
        burst_ticks = burst_ticks + 1'b1;
        // zero half period toggles every tick; a full counter acts as the limit
        if (burst_ticks >= cfg_half || &burst_ticks) begin
          trig_level   = ~trig_level;
          burst_ticks  = '0;
          toggles_left = toggles_left - 1'b1;
          if (toggles_left == 8'd0) begin
            phase_q    = PH_ECHO;
            echo_ticks = '0;
          end
        end
      end
      PH_ECHO: begin
        if (!echo) begin
          prod    = PROD_W'(echo_ticks) * PROD_W'(cfg_scale);
          cm_full = prod[PROD_W-1:16];
          if (32'(cm_full) > 32'(DIST_MAX)) last_cm = DIST_MAX;
          else last_cm = DIST_W'(32'(cm_full));
          r.done  = 1'b1;
          phase_q = PH_IDLE;
        end else begin
          echo_ticks = echo_ticks + 1'b1;
          // zero limit times out on the first high tick
          if (echo_ticks >= cfg_limit || &echo_ticks) begin
            last_cm     = TIMEOUT_CM;
            r.done      = 1'b1;
            r.timed_out = 1'b1;
            phase_q     = PH_IDLE;
          end
        end
      end
      default: phase_q = PH_IDLE;
    endcase
    r.trigger     = trig_level;
    r.busy        = (phase_q != PH_IDLE);
    r.distance_cm = last_cm;
    return r;
  endfunction

  task automatic report(input string what, input int got, input int want);
    errors++;
    // keep the log bounded when the DUT is badly off
    if (errors <= MAX_PRINTS)
      $display("[%0t] tick result %s: got %0d, want %0d", $time, what, got, want);
  endtask

  // Offer one tick beat. Entered between a rising and a falling edge; returns
  // at the accepting edge with valid still high, so back-to-back beats need no
  // drop of valid.
  task automatic send_tick(input logic start, input logic echo);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    start_req  <= start;
    echo_level <= echo;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(advance_tick(start, echo));
    ticks_sent++;
  endtask

  // Register write once the DUT is idle and every result is back.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_HALF_PERIOD: cfg_half    = data;
      REG_BURST:       cfg_toggles = data[7:0];
      REG_ECHO_LIMIT:  cfg_limit   = data;
      REG_SCALE:       cfg_scale   = data;
      default: ;
    endcase
  endtask

  task automatic set_ranger(input int half, input int toggles, input int limit, input int scale);
    cfg_write(REG_HALF_PERIOD, CFG_DATA_W'(half));
    cfg_write(REG_BURST, CFG_DATA_W'(toggles));
    cfg_write(REG_ECHO_LIMIT, CFG_DATA_W'(limit));
    cfg_write(REG_SCALE, CFG_DATA_W'(scale));
  endtask

  // One full measurement: start, ride out the burst with junk on echo, then
  // hold echo high for echo_len ticks (or until timeout). Start is either
  // held high throughout or random, both ignored while busy.
  task automatic range_once(input int echo_len, input bit start_held);
    int held;
    held = 0;
    send_tick(1'b1, 1'($urandom));
    while (phase_q != PH_IDLE) begin
      if (phase_q == PH_ECHO) begin
        send_tick(start_held | 1'($urandom), held < echo_len);
        held++;
      end else begin
        send_tick(start_held | 1'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic test_reset_config();
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    range_once(60, 1'b0);  // 120-tick burst, floor(60 * 0.017) = 1 cm
  endtask

  task automatic test_start_while_busy();
    set_ranger(2, 2, 50, int'(RST_SCALE));
    range_once(5, 1'b1);
    send_tick(1'b0, 1'b1);
  endtask

  task automatic test_zero_half_period();
    cfg_write(REG_HALF_PERIOD, CFG_DATA_W'(0));
    cfg_write(REG_BURST, CFG_DATA_W'(3));
    range_once(4, 1'b0);
  endtask

  task automatic test_zero_toggles();
    cfg_write(REG_BURST, CFG_DATA_W'(0));
    range_once(3, 1'b0);
    range_once(0, 1'b0);
  endtask

  task automatic test_zero_echo_limit();
    set_ranger(1, 1, 0, 65535);
    range_once(5, 1'b0);  // times out on the first high tick
    range_once(0, 1'b0);  // echo already low: zero distance
  endtask

  task automatic test_toggle_extremes();
    set_ranger(1, 255, 65535, int'(RST_SCALE));
    range_once(2, 1'b0);
    cfg_write(REG_BURST, CFG_DATA_W'(1));
    range_once(1, 1'b0);
  endtask

  // Near-unity scale gives one cm per tick less the floor; zero scale gives 0.
  task automatic test_distance_limits();
    set_ranger(1, 1, 65535, 65535);
    range_once(60, 1'b0);
    cfg_write(REG_SCALE, CFG_DATA_W'(0));
    range_once(10, 1'b0);
  endtask

  // Receiver holds off while ticks keep coming; the result register fills
  // and in_ready must drop until the hold ends.
  task automatic test_output_backpressure();
    set_ranger(2, 3, 100, int'(RST_SCALE));
    idle_on  = 1'b0;
    hold_len = 60;
    hold_requests++;
    range_once(30, 1'b0);
    idle_on = 1'b1;
  endtask

  // Random settings per phase, mostly clean measurements plus some noise.
  task automatic test_random_ranging(input int n_ticks, input bit allow_idle);
    int goal;
    goal = ticks_sent + n_ticks;
    while (ticks_sent < goal) begin
      idle_on = allow_idle && ($urandom_range(0, 3) != 0);
      set_ranger($urandom_range(0, 5), $urandom_range(0, 6),
                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(9, 60),
                 $urandom);
      repeat ($urandom_range(1, 4)) begin
        repeat ($urandom_range(0, 3)) send_tick(1'b0, 1'($urandom));
        if ($urandom_range(0, 7) == 0) begin
          // raw noise, then let any measurement it started run out
          repeat (6) send_tick(1'($urandom), 1'($urandom));
          while (phase_q != PH_IDLE) send_tick(1'($urandom), 1'($urandom));
        end else begin
          range_once($urandom_range(0, 70), $urandom_range(0, 5) == 0);
        end
      end
    end
  endtask

  // Receiver: random stall bursts, plus any long hold a test posts.
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 7) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Checker: every taken result beat against the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report("beat with nothing expected", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (trigger !== want.trigger)
          report("trigger", int'(trigger), int'(want.trigger));
        if (busy_res !== want.busy)
          report("busy_res", int'(busy_res), int'(want.busy));
        if (done_res !== want.done)
          report("done_res", int'(done_res), int'(want.done));
        if (timed_out !== want.timed_out)
          report("timed_out", int'(timed_out), int'(want.timed_out));
        if (distance_cm !== want.distance_cm)
          report("distance_cm", int'(distance_cm), int'(want.distance_cm));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_config();
    test_start_while_busy();
    test_zero_half_period();
    test_zero_toggles();
    test_zero_echo_limit();
    test_toggle_extremes();
    test_distance_limits();
    test_output_backpressure();
    test_random_ranging(60, 1'b1);
    test_random_ranging(40, 1'b0);  // closing stretch, no gaps or stalls

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
